@@ rtl/core/contiguous_block_allocator_defines.svh @@
// Assertion macros used by the block allocator top level.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBAL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBAL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cbal_pkg.sv @@
// Shared types and constants of the contiguous block allocator.
package cbal_pkg;

	localparam int KIND_W  = 2;
	localparam int SIZE_W  = 20;
	localparam int IDX_W   = 8;
	localparam int INODE_W = 8;
	localparam int COUNT_W = 9;

	localparam logic [KIND_W-1:0] KIND_FIND_RUN   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MARK_BUSY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIND_INODE = 2'd2;

	// Search command held steady for the whole walk along the cell row
	typedef struct packed {
		logic               seek_inode;
		logic [SIZE_W-1:0]  size;
		logic [INODE_W-1:0] inode;
	} cbal_cmd_t;

	// Control part of the search wave handed from cell to cell
	typedef struct packed {
		logic active;
		logic hit;
	} cbal_wave_t;

endpackage

@@ rtl/core/cbal_req_if.sv @@
// Request channel: valid/ready handshake with the request fields.
interface cbal_req_if
	import cbal_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [SIZE_W-1:0]  size_bytes;
	logic [IDX_W-1:0]   block_index;
	logic [INODE_W-1:0] inode_number;

	modport source (output valid, kind, size_bytes, block_index, inode_number, input ready);
	modport sink (input valid, kind, size_bytes, block_index, inode_number, output ready);
endinterface

@@ rtl/core/cbal_rsp_if.sv @@
// Result channel: valid/ready handshake with the result fields.
interface cbal_rsp_if
	import cbal_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               found;
	logic [IDX_W-1:0]   block_start;
	logic [COUNT_W-1:0] block_count;
	logic [IDX_W-1:0]   highest_used;

	modport source (output valid, found, block_start, block_count, highest_used, input ready);
	modport sink (input valid, found, block_start, block_count, highest_used, output ready);
endinterface

@@ rtl/core/cbal_cell.sv @@
// One block of the map: free bit, owner tag and one stage of the search wave.
module cbal_cell
	import cbal_pkg::*;
#(
	parameter int NUM_BLOCKS  = 256,
	parameter int BLOCK_BYTES = 512,
	parameter int IDX         = 0
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  cbal_cmd_t                                  cmd,
	input  logic                                       wr_en,
	input  logic [INODE_W-1:0]                         wr_inode,
	input  cbal_wave_t                                 wave_in,
	input  logic [$clog2(NUM_BLOCKS+1)-1:0]            run_in,
	input  logic [$clog2(2**SIZE_W+BLOCK_BYTES)-1:0]   bytes_in,
	input  logic [$clog2(NUM_BLOCKS)-1:0]              start_in,
	output cbal_wave_t                                 wave_out,
	output logic [$clog2(NUM_BLOCKS+1)-1:0]            run_out,
	output logic [$clog2(2**SIZE_W+BLOCK_BYTES)-1:0]   bytes_out,
	output logic [$clog2(NUM_BLOCKS)-1:0]              start_out
);
	localparam int IW  = $clog2(NUM_BLOCKS);
	localparam int CW  = $clog2(NUM_BLOCKS+1);
	localparam int RBW = $clog2(2**SIZE_W + BLOCK_BYTES);

	logic               free_q;
	logic               owned_q;
	logic [INODE_W-1:0] owner_q;

	cbal_wave_t         wave_d, wave_q;
	logic [CW-1:0]      run_d, run_q;
	logic [RBW-1:0]     bytes_d, bytes_q;
	logic [IW-1:0]      start_d, start_q;
	logic [RBW-1:0]     bytes_inc;

	// Mark the block busy and tag its owner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= 1'b1;
			owned_q <= 1'b0;
		end else if (wr_en) begin
			free_q  <= 1'b0;
			owned_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			owner_q <= wr_inode;
		end
	end

	assign bytes_inc = bytes_in + RBW'(BLOCK_BYTES);

	// Advance the wave by one block: extend or break the free run, or match the owner
	always_comb begin
		wave_d  = wave_in;
		run_d   = run_in;
		bytes_d = bytes_in;
		start_d = start_in;
		if (!wave_in.hit) begin
			if (cmd.seek_inode) begin
				if (owned_q && (owner_q == cmd.inode)) begin
					wave_d.hit = 1'b1;
					start_d    = IW'(IDX);
				end
			end else if (free_q) begin
				run_d   = run_in + CW'(1);
				bytes_d = bytes_inc;
				start_d = IW'(IDX) - run_in[IW-1:0];
				if (bytes_inc >= RBW'(cmd.size)) begin
					wave_d.hit = 1'b1;
				end
			end else begin
				run_d   = '0;
				bytes_d = '0;
			end
		end
	end

	// Hand the wave to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= wave_d;
		end
	end

	always_ff @(posedge clk) begin
		run_q      <= run_d;
		bytes_q    <= bytes_d;
		start_q    <= start_d;
	end

	assign wave_out  = wave_q;
	assign run_out   = run_q;
	assign bytes_out = bytes_q;
	assign start_out = start_q;

endmodule

@@ rtl/core/contiguous_block_allocator.sv @@
// Contiguous block allocator: a row of block cells searched by a travelling wave.
//
// Requests arrive on req (valid/ready), results leave on rsp (valid/ready),
// one result beat for every request beat, in order, one request at a time.
// Kind 0 finds the lowest run of free blocks holding size_bytes (size 0 asks
// for one block); kind 1 marks block_index busy with owner inode_number;
// kind 2 finds the lowest block owned by inode_number; kind 3 answers not found.
// Searches (kinds 0 and 2) send a wave down the row of NUM_BLOCKS cells, one
// cell per cycle; the request beat launches it from inject_q, it passes each
// cell register in turn, and the end of the row loads the result. Mark-busy and
// kind 3 answer in the cycle after the request beat.
// The result sits in an output register; a new request is taken once no search
// is open and that register is empty or being read, so a stalled receiver holds
// off requests. Reset leaves every block free and unowned and the highest-used
// mark at 0; no clearing pass is needed.
module contiguous_block_allocator
	import cbal_pkg::*;
#(
	parameter int NUM_BLOCKS  = 256,
	parameter int BLOCK_BYTES = 512
) (
	input  logic     clk,
	input  logic     arst_n,
	cbal_req_if.sink req,
	cbal_rsp_if.source rsp
);
	`include "contiguous_block_allocator_defines.svh"

	localparam int IW  = $clog2(NUM_BLOCKS);
	localparam int CW  = $clog2(NUM_BLOCKS+1);
	localparam int RBW = $clog2(2**SIZE_W + BLOCK_BYTES);

	logic               busy_q;
	logic               inject_q;
	cbal_cmd_t          cmd_q;
	logic [IDX_W-1:0]   highest_q;

	logic               out_vld_q;
	logic               out_found_q;
	logic [IDX_W-1:0]   out_start_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               accept;
	logic               is_search;
	logic               idx_ok;
	logic               mark;
	logic               walk_done;

	cbal_wave_t         wave  [0:NUM_BLOCKS];
	logic [CW-1:0]      run   [0:NUM_BLOCKS];
	logic [RBW-1:0]     bytes [0:NUM_BLOCKS];
	logic [IW-1:0]      start [0:NUM_BLOCKS];
	logic [NUM_BLOCKS:0] tok_vec;
	logic [NUM_BLOCKS-1:0] wr_en;

	assign req.ready = !busy_q && (!out_vld_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign is_search = (req.kind == KIND_FIND_RUN) || (req.kind == KIND_FIND_INODE);
	assign idx_ok    = int'(req.block_index) < NUM_BLOCKS;
	assign mark      = accept && (req.kind == KIND_MARK_BUSY) && idx_ok;
	assign walk_done = wave[NUM_BLOCKS].active;

	// Hold the search command and launch the wave into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			inject_q <= 1'b0;
		end else begin
			inject_q <= accept && is_search;
			if (accept && is_search) begin
				busy_q <= 1'b1;
			end else if (walk_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_search) begin
			cmd_q.seek_inode <= (req.kind == KIND_FIND_INODE);
			cmd_q.size       <= (req.size_bytes == '0) ? SIZE_W'(1) : req.size_bytes;
			cmd_q.inode      <= req.inode_number;
		end
	end

	// Raise the highest-used mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= '0;
		end else if (mark && (req.block_index > highest_q)) begin
			highest_q <= req.block_index;
		end
	end

	// Seed the head of the row
	assign wave[0].active = inject_q;
	assign wave[0].hit    = 1'b0;
	assign run[0]         = '0;
	assign bytes[0]       = '0;
	assign start[0]       = '0;
	assign tok_vec[0]     = inject_q;

	for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
		assign wr_en[i]     = mark && (int'(req.block_index) == i);
		assign tok_vec[i+1] = wave[i+1].active;

		cbal_cell #(
			.NUM_BLOCKS  (NUM_BLOCKS),
			.BLOCK_BYTES (BLOCK_BYTES),
			.IDX         (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd_q),
			.wr_en     (wr_en[i]),
			.wr_inode  (req.inode_number),
			.wave_in   (wave[i]),
			.run_in    (run[i]),
			.bytes_in  (bytes[i]),
			.start_in  (start[i]),
			.wave_out  (wave[i+1]),
			.run_out   (run[i+1]),
			.bytes_out (bytes[i+1]),
			.start_out (start[i+1])
		);
	end

	// Load the result register from a direct answer or from the end of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((accept && !is_search) || walk_done) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_search) begin
			out_found_q <= mark;
			out_start_q <= mark ? req.block_index : '0;
			out_count_q <= '0;
		end else if (walk_done) begin
			out_found_q <= wave[NUM_BLOCKS].hit;
			out_start_q <= wave[NUM_BLOCKS].hit ?
				IDX_W'({{IDX_W{1'b0}}, start[NUM_BLOCKS]}) : '0;
			out_count_q <= (wave[NUM_BLOCKS].hit && !cmd_q.seek_inode) ?
				COUNT_W'({{COUNT_W{1'b0}}, run[NUM_BLOCKS]}) : '0;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.found        = out_found_q;
	assign rsp.block_start  = out_start_q;
	assign rsp.block_count  = out_count_q;
	assign rsp.highest_used = highest_q;

	// At most one wave travels the row
	`CBAL_ASSERT_NOW(a_one_wave, clk, arst_n, 1'b1, $onehot0(tok_vec), "more than one search wave")
	// A search request launches a wave next cycle
	`CBAL_ASSERT_NEXT(a_launch, clk, arst_n, accept && is_search, inject_q, "search not launched")
	// A wave reaches the end only while a search is open
	`CBAL_ASSERT_NOW(a_end_busy, clk, arst_n, walk_done, busy_q && !out_vld_q, "stray wave end")
	// The end of a walk presents a result and clears the busy flag
	`CBAL_ASSERT_NEXT(a_end_result, clk, arst_n, walk_done, out_vld_q && !busy_q, "walk lost")

endmodule
